// ===== rtl/svoe_pkg.sv =====
// shared types, codes and tables for the sid voice oscillator/envelope block
`default_nettype none
package svoe_pkg;

    // envelope phase codes
    localparam logic [1:0] PH_ATTACK  = 2'd0;
    localparam logic [1:0] PH_DECAY   = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    // register offsets inside one voice's block of seven
    localparam logic [2:0] REG_FREQ_LO  = 3'd0;
    localparam logic [2:0] REG_FREQ_HI  = 3'd1;
    localparam logic [2:0] REG_PULSE_LO = 3'd2;
    localparam logic [2:0] REG_PULSE_HI = 3'd3;
    localparam logic [2:0] REG_CONTROL  = 3'd4;
    localparam logic [2:0] REG_ATK_DEC  = 3'd5;
    localparam logic [2:0] REG_SUS_REL  = 3'd6;

    localparam logic [4:0] ADDR_VOICE1    = 5'd7;
    localparam logic [4:0] ADDR_VOICE2    = 5'd14;
    localparam logic [4:0] ADDR_VOICE_END = 5'd21;
    localparam logic [4:0] ADDR_RES_ROUTE = 5'd23;
    localparam logic [4:0] ADDR_MODE_VOL  = 5'd24;

    // waveform select codes (control bits 7:4)
    localparam logic [3:0] WAVE_TRI   = 4'h1;
    localparam logic [3:0] WAVE_SAW   = 4'h2;
    localparam logic [3:0] WAVE_PULSE = 4'h4;
    localparam logic [3:0] WAVE_NOISE = 4'h8;

    localparam logic [22:0] LFSR_SEED = 23'h7ffff8;

    typedef struct packed {
        logic [23:0] acc;
        logic [22:0] lfsr;
        logic        msb_prev;
        logic        b19_prev;
        logic [14:0] rate_cnt;
        logic [1:0]  phase;
        logic [7:0]  exp_cnt;
        logic [4:0]  exp_period;
        logic [7:0]  env;
        logic        gate_prev;
        logic        hold_zero;
    } t_voice_state;

    localparam t_voice_state VOICE_RESET = '{
        acc: 24'd0, lfsr: LFSR_SEED, msb_prev: 1'b0, b19_prev: 1'b0,
        rate_cnt: 15'd0, phase: PH_RELEASE, exp_cnt: 8'd0, exp_period: 5'd1,
        env: 8'd0, gate_prev: 1'b0, hold_zero: 1'b1
    };

    function automatic logic [14:0] rate_period(input logic [3:0] sel);
        logic [14:0] r;
        case (sel)
            4'd0:    r = 15'd9;
            4'd1:    r = 15'd32;
            4'd2:    r = 15'd63;
            4'd3:    r = 15'd95;
            4'd4:    r = 15'd149;
            4'd5:    r = 15'd220;
            4'd6:    r = 15'd267;
            4'd7:    r = 15'd313;
            4'd8:    r = 15'd392;
            4'd9:    r = 15'd977;
            4'd10:   r = 15'd1965;
            4'd11:   r = 15'd3126;
            4'd12:   r = 15'd3907;
            4'd13:   r = 15'd11720;
            4'd14:   r = 15'd19532;
            default: r = 15'd31251;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/svoe_in_if.sv =====
// input channel: register writes and chip clock ticks
`default_nettype none
interface svoe_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [4:0] address;
    logic [7:0] data;

    modport source (output valid, output operation, output address, output data, input ready);
    modport sink   (input valid, input operation, input address, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/svoe_out_if.sv =====
// output channel: per-tick waveforms, envelopes and mode bits
`default_nettype none
interface svoe_out_if;
    logic              valid;
    logic              ready;
    logic signed [11:0] wave_a;
    logic signed [11:0] wave_b;
    logic signed [11:0] wave_c;
    logic [7:0]        env_a;
    logic [7:0]        env_b;
    logic [7:0]        env_c;
    logic [3:0]        master_volume;
    logic [2:0]        filter_route;

    modport source (output valid, output wave_a, output wave_b, output wave_c,
                    output env_a, output env_b, output env_c,
                    output master_volume, output filter_route, input ready);
    modport sink   (input valid, input wave_a, input wave_b, input wave_c,
                    input env_a, input env_b, input env_c,
                    input master_volume, input filter_route, output ready);
endinterface
`default_nettype wire

// ===== rtl/svoe_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module svoe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/svoe_update.sv =====
// one voice's oscillator and envelope step for one chip tick
`default_nettype none
module svoe_update
    import svoe_pkg::*;
(
    input  wire t_voice_state i_state,
    input  wire logic [15:0]  i_freq,
    input  wire logic [7:0]   i_ctrl,
    input  wire logic [7:0]   i_atk_dec,
    input  wire logic [7:0]   i_sus_rel,
    output t_voice_state      o_state,
    output logic              o_rise
);
    t_voice_state s;
    logic [23:0]  acc;
    logic         gate;
    logic [3:0]   sel;
    logic         go;
    logic [7:0]   sustain;

    always_comb begin
        s    = i_state;
        gate = i_ctrl[0];
        acc  = i_state.acc + {8'd0, i_freq};
        s.acc = acc;
        o_rise = acc[23] & ~i_state.msb_prev;
        s.msb_prev = acc[23];
        if (acc[19] && !i_state.b19_prev) begin
            s.lfsr = {i_state.lfsr[21:0], i_state.lfsr[22] ^ i_state.lfsr[17]};
        end
        s.b19_prev = acc[19];

        if (gate && !i_state.gate_prev) begin
            s.phase     = PH_ATTACK;
            s.hold_zero = 1'b0;
        end else if (!gate && i_state.gate_prev) begin
            s.phase = PH_RELEASE;
        end
        s.gate_prev = gate;

        // counter skips zero when it wraps past 0x7fff
        s.rate_cnt = (i_state.rate_cnt == 15'h7fff) ? 15'd1 : i_state.rate_cnt + 15'd1;

        case (s.phase)
            PH_ATTACK: sel = i_atk_dec[7:4];
            PH_DECAY:  sel = i_atk_dec[3:0];
            default:   sel = i_sus_rel[3:0];
        endcase
        sustain = {i_sus_rel[7:4], i_sus_rel[7:4]};
        go = 1'b0;

        if (s.rate_cnt == rate_period(sel)) begin
            s.rate_cnt = 15'd0;
            go = (s.phase == PH_ATTACK);
            if (!go) begin
                s.exp_cnt = s.exp_cnt + 8'd1;
                go = (s.exp_cnt == {3'd0, s.exp_period});
            end
            if (go) begin
                s.exp_cnt = 8'd0;
                if (!s.hold_zero) begin
                    case (s.phase)
                        PH_ATTACK: begin
                            s.env = s.env + 8'd1;
                            if (s.env == 8'hff) begin
                                s.phase = PH_DECAY;
                            end
                        end
                        PH_DECAY: begin
                            if (s.env != sustain) begin
                                s.env = s.env - 8'd1;
                            end
                        end
                        default: s.env = s.env - 8'd1;
                    endcase
                    case (s.env)
                        8'hff: s.exp_period = 5'd1;
                        8'h5d: s.exp_period = 5'd2;
                        8'h36: s.exp_period = 5'd4;
                        8'h1a: s.exp_period = 5'd8;
                        8'h0e: s.exp_period = 5'd16;
                        8'h06: s.exp_period = 5'd30;
                        8'h00: begin
                            s.exp_period = 5'd1;
                            s.hold_zero  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
        o_state = s;
    end
endmodule
`default_nettype wire

// ===== rtl/sid_voice_oscillator_envelope.sv =====
// top level: chained sid-style voices with memory-held voice state
//
// Register writes (operation 0) are applied when they are accepted. A clock tick
// (operation 1) steps through the states P1, P2 and DONE: the voice
// state lives in one memory with a single read port, and a tick sweeps it
// twice, once to advance oscillators and envelopes, once to apply hard sync
// and form the waveforms, then loads the result register in DONE.
// The next item is taken on the cycle the result register is loaded, and a
// finished result may wait in that register while a new item is accepted.
// Voice state reads as its reset value until first written after reset,
// so no clearing pass is needed.
`default_nettype none
module sid_voice_oscillator_envelope
    import svoe_pkg::*;
#(
    parameter int NUM_VOICES = 3
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    svoe_in_if.sink     i_in,
    svoe_out_if.source  o_out
);
    localparam int VW = $clog2(NUM_VOICES);
    localparam int SW = $clog2(NUM_VOICES + 1);
    localparam int SB = $bits(t_voice_state);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_P1   = 2'd1;
    localparam logic [1:0] ST_P2   = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [SW-1:0] r_step,  n_step;

    logic [15:0] r_freq  [NUM_VOICES];
    logic [11:0] r_pulse [NUM_VOICES];
    logic [7:0]  r_ctrl  [NUM_VOICES];
    logic [7:0]  r_ad    [NUM_VOICES];
    logic [7:0]  r_sr    [NUM_VOICES];
    logic [3:0]  r_volume;
    logic [2:0]  r_route;

    logic [NUM_VOICES-1:0] r_valid;
    logic                  r_rd_valid;
    logic [NUM_VOICES-1:0] r_rise;
    logic [NUM_VOICES-1:0] r_msb;

    logic [11:0] r_stage_wave [3];
    logic [7:0]  r_stage_env  [3];

    logic               r_out_valid;
    logic signed [11:0] r_out_wave [3];
    logic [7:0]         r_out_env  [3];
    logic [3:0]         r_out_vol;
    logic [2:0]         r_out_route;

    logic          out_free, in_ready, in_xfer, tick_xfer, wr_xfer;
    logic          proc, proc_p1, proc_p2, last_step, load_out;
    logic [VW-1:0] pv, pv_prev, raddr;
    logic [SB-1:0] ram_q, ram_wdata;
    t_voice_state  st, st_upd, st_p2;
    logic          upd_rise;

    logic [NUM_VOICES-1:0] sync_req, sync_clr;
    logic                  ring_msb;
    logic [23:0]           acc_f;
    logic [22:0]           lf;
    logic [11:0]           wave;
    logic [7:0]            ctl;

    logic [1:0]    wv;
    logic [2:0]    wr;
    logic [VW-1:0] wi;
    logic          wv_ok;

    // ------------------------------------------------------------ handshake
    assign out_free  = ~r_out_valid | o_out.ready;
    assign in_ready  = (r_state == ST_IDLE) || (r_state == ST_DONE && out_free);
    assign i_in.ready = in_ready;
    assign in_xfer   = i_in.valid & in_ready;
    assign tick_xfer = in_xfer & i_in.operation;
    assign wr_xfer   = in_xfer & ~i_in.operation;
    assign load_out  = (r_state == ST_DONE) && out_free;

    // ------------------------------------------------------------ sequencer
    assign proc      = (r_state == ST_P1 || r_state == ST_P2) && (r_step != '0);
    assign proc_p1   = proc && (r_state == ST_P1);
    assign proc_p2   = proc && (r_state == ST_P2);
    assign last_step = (r_step == SW'(NUM_VOICES));
    assign pv        = VW'(r_step - SW'(1));
    assign pv_prev   = (pv == '0) ? VW'(NUM_VOICES - 1) : pv - VW'(1);
    assign raddr     = VW'(r_step);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (tick_xfer) begin
                    n_state = ST_P1;
                    n_step  = '0;
                end
            end
            ST_P1: begin
                n_step = r_step + SW'(1);
                if (last_step) begin
                    n_state = ST_P2;
                    n_step  = '0;
                end
            end
            ST_P2: begin
                n_step = r_step + SW'(1);
                if (last_step) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (tick_xfer) begin
                    n_state = ST_P1;
                    n_step  = '0;
                end else if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------ state memory
    assign st = r_rd_valid ? t_voice_state'(ram_q) : VOICE_RESET;

    svoe_update u_update (
        .i_state   (st),
        .i_freq    (r_freq[pv]),
        .i_ctrl    (r_ctrl[pv]),
        .i_atk_dec (r_ad[pv]),
        .i_sus_rel (r_sr[pv]),
        .o_state   (st_upd),
        .o_rise    (upd_rise)
    );

    // hard sync: a voice synced this tick blocks the sync of the next one
    for (genvar g = 0; g < NUM_VOICES; g++) begin : g_sync
        localparam int P  = (g + NUM_VOICES - 1) % NUM_VOICES;
        assign sync_req[g] = r_ctrl[g][1] & r_rise[P];
    end
    for (genvar g = 0; g < NUM_VOICES; g++) begin : g_clr
        localparam int P  = (g + NUM_VOICES - 1) % NUM_VOICES;
        assign sync_clr[g] = sync_req[g] & ~sync_req[P];
    end

    always_comb begin
        st_p2 = st;
        if (sync_clr[pv]) begin
            st_p2.acc = 24'd0;
        end
    end

    assign ram_wdata = proc_p1 ? SB'(st_upd) : SB'(st_p2);

    svoe_ram #(.WIDTH(SB), .DEPTH(NUM_VOICES)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (proc),
        .i_waddr (pv),
        .i_wdata (ram_wdata),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // ------------------------------------------------------------ waveform
    always_comb begin
        acc_f    = st_p2.acc;
        lf       = st_p2.lfsr;
        ctl      = r_ctrl[pv];
        ring_msb = ctl[2] & r_msb[pv_prev] & ~sync_clr[pv_prev];
        case (ctl[7:4])
            WAVE_TRI:   wave = (acc_f[23] ^ ring_msb) ? ~acc_f[22:11] : acc_f[22:11];
            WAVE_SAW:   wave = acc_f[23:12];
            WAVE_PULSE: wave = (acc_f[23:12] >= r_pulse[pv]) ? 12'hfff : 12'h000;
            WAVE_NOISE: wave = {lf[22], lf[20], lf[16], lf[13], lf[11], lf[7], lf[4], lf[2],
                                4'h0};
            default:    wave = 12'h000;
        endcase
    end

    // ------------------------------------------------------------ write decode
    always_comb begin
        if (i_in.address < ADDR_VOICE1) begin
            wv = 2'd0;
            wr = i_in.address[2:0];
        end else if (i_in.address < ADDR_VOICE2) begin
            wv = 2'd1;
            wr = 3'(i_in.address - ADDR_VOICE1);
        end else begin
            wv = 2'd2;
            wr = 3'(i_in.address - ADDR_VOICE2);
        end
        wi    = VW'(wv);
        wv_ok = (i_in.address < ADDR_VOICE_END) && (int'(wv) < NUM_VOICES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_freq[i]  <= '0;
                r_pulse[i] <= '0;
                r_ctrl[i]  <= '0;
                r_ad[i]    <= '0;
                r_sr[i]    <= '0;
            end
            r_volume <= '0;
            r_route  <= '0;
        end else if (wr_xfer) begin
            if (wv_ok) begin
                case (wr)
                    REG_FREQ_LO:  r_freq[wi][7:0]   <= i_in.data;
                    REG_FREQ_HI:  r_freq[wi][15:8]  <= i_in.data;
                    REG_PULSE_LO: r_pulse[wi][7:0]  <= i_in.data;
                    REG_PULSE_HI: r_pulse[wi][11:8] <= i_in.data[3:0];
                    REG_CONTROL:  r_ctrl[wi]        <= i_in.data;
                    REG_ATK_DEC:  r_ad[wi]          <= i_in.data;
                    REG_SUS_REL:  r_sr[wi]          <= i_in.data;
                    default: ;
                endcase
            end else if (i_in.address == ADDR_RES_ROUTE) begin
                r_route <= i_in.data[2:0];
            end else if (i_in.address == ADDR_MODE_VOL) begin
                r_volume <= i_in.data[3:0];
            end
        end
    end

    // ------------------------------------------------------------ control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_rd_valid <= r_valid[raddr];
            if (proc) begin
                r_valid[pv] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------ payload regs
    always_ff @(posedge i_clk) begin
        if (proc_p1) begin
            r_rise[pv] <= upd_rise;
            r_msb[pv]  <= st_upd.acc[23];
        end
        for (int i = 0; i < 3; i++) begin
            if (proc_p2 && int'(pv) == i) begin
                r_stage_wave[i] <= wave;
                r_stage_env[i]  <= st_p2.env;
            end
        end
        if (load_out) begin
            for (int i = 0; i < 3; i++) begin
                r_out_wave[i] <= (i < NUM_VOICES) ? signed'(r_stage_wave[i] ^ 12'h800) : '0;
                r_out_env[i]  <= (i < NUM_VOICES) ? r_stage_env[i] : '0;
            end
            r_out_vol   <= r_volume;
            r_out_route <= r_route;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.wave_a        = r_out_wave[0];
    assign o_out.wave_b        = r_out_wave[1];
    assign o_out.wave_c        = r_out_wave[2];
    assign o_out.env_a         = r_out_env[0];
    assign o_out.env_b         = r_out_env[1];
    assign o_out.env_c         = r_out_env[2];
    assign o_out.master_volume = r_out_vol;
    assign o_out.filter_route  = r_out_route;

`ifndef NO_ASSERTIONS
    // the memory is never read and written at the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_step != SW'(NUM_VOICES)) |-> (raddr != pv))
        else $error("state memory read and write hit the same voice");

    // a sweep over the voices runs to its end before the next phase
    a_p1_to_p2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_P1 && last_step) |=> (r_state == ST_P2 && r_step == '0))
        else $error("oscillator sweep did not hand over to sync sweep");

    // the result register is only loaded when it is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable(r_out_wave[0]) && $stable(r_out_env[0]))
        else $error("pending result overwritten");

    // items are only taken between ticks
    a_accept_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> (r_state == ST_IDLE || r_state == ST_DONE))
        else $error("item accepted during a tick");
`endif
endmodule
`default_nettype wire
